// File: hw/rtl/xkxd_pkg.sv
// shared types and constants for the keystream xor decrypt unit
`default_nettype none

package xkxd_pkg;

    localparam int TABLE_WORDS_DEF  = 1024;
    localparam int HEAD_WORDS_DEF   = 512;
    localparam int STRIDE_WORDS_DEF = 64;
    localparam int ROUND_COUNT_DEF  = 6;

    localparam int WORD_W        = 32;
    localparam int TABLE_INDEX_W = 10;
    localparam int CFG_INDEX_W   = 3;

    localparam logic [WORD_W-1:0] KS_DELTA = 32'h9E37_79B9;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_ZERO      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_ONE       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_TWO       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_THREE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_STREAM_PRESET = 3'd4;

    // input operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DATA = 1'b1;

    typedef struct packed {
        logic                     op;
        logic [TABLE_INDEX_W-1:0] table_index;
        logic [WORD_W-1:0]        word_value;
        logic                     first_word;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] out_word;
        logic              was_masked;
    } t_out_item;

endpackage

`default_nettype wire

// File: hw/rtl/xkxd_ram.sv
// generic single write port ram with registered read
`default_nettype none

module xkxd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/xxtea_keystream_xor_decrypt_unit.sv
// keystream xor decrypt unit with in-place xxtea keystream generation
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  in      | input     | i_in_valid/o_in_stall   | i_in_item (t_in_item)
//  out     | output    | o_out_valid/i_out_stall | o_out_item (t_out_item)
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// a load writes the table while idle; a payload word does one table read, then outputs.
// after a reset or load, with no preset, the first payload word also runs ROUND_COUNT
// generation rounds over the table, on the single shared mix/add unit and one ram port
// reset is synchronous active low and clears control state; table contents stay undefined
// the unit accepts a new transaction while a finished result waits on a stalled output
`default_nettype none

module xxtea_keystream_xor_decrypt_unit import xkxd_pkg::*; #(
    parameter int TABLE_WORDS  = TABLE_WORDS_DEF,
    parameter int HEAD_WORDS   = HEAD_WORDS_DEF,
    parameter int STRIDE_WORDS = STRIDE_WORDS_DEF,
    parameter int ROUND_COUNT  = ROUND_COUNT_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire t_in_item               i_in_item,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output t_out_item                   o_out_item,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [WORD_W-1:0]      i_cfg_data
);

    localparam int AW    = $clog2(TABLE_WORDS);
    localparam int RW    = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
    localparam int PW    = (STRIDE_WORDS > 1) ? $clog2(STRIDE_WORDS) : 1;
    localparam int XW    = ((AW > TABLE_INDEX_W) ? AW : TABLE_INDEX_W) + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_WORDS - 1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_RSTART = 9'b000000010,
        S_RZ     = 9'b000000100,
        S_RCUR   = 9'b000001000,
        S_GRD    = 9'b000010000,
        S_GMIX   = 9'b000100000,
        S_GWR    = 9'b001000000,
        S_DRD    = 9'b010000000,
        S_DOUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [WORD_W-1:0] r_key [4];
    logic              r_cfg_preset;

    logic              r_stream_ready;
    logic [WORD_W-1:0] r_pos;
    logic [PW-1:0]     r_phase;
    logic [AW-1:0]     r_ptr;
    logic [WORD_W-1:0] r_sum;
    logic [RW-1:0]     r_round;
    logic [AW-1:0]     r_gp;
    logic [WORD_W-1:0] r_z;
    logic [WORD_W-1:0] r_cur;
    logic [WORD_W-1:0] r_y;
    logic [WORD_W-1:0] r_mix;
    logic [WORD_W-1:0] r_word;
    logic              r_first;
    logic              r_masked;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic              in_accept;
    logic [XW-1:0]     load_idx_ext;
    logic              load_in_range;
    logic              load_we;
    logic              ram_we;
    logic [AW-1:0]     ram_wr_addr;
    logic [WORD_W-1:0] ram_wr_data;
    logic              ram_re;
    logic [AW-1:0]     ram_rd_addr;
    logic [WORD_W-1:0] ram_rd_data;
    logic [1:0]        round_e;
    logic [1:0]        key_sel;
    logic [WORD_W-1:0] key_word;
    logic [WORD_W-1:0] mix_a;
    logic [WORD_W-1:0] mix_b;
    logic [WORD_W-1:0] gen_new;
    logic [AW-1:0]     gp_inc;
    logic [WORD_W-1:0] pos_eff;
    logic [PW-1:0]     phase_eff;
    logic [AW-1:0]     ptr_eff;
    logic              data_masked;
    logic              out_free;

    assign in_accept     = i_in_valid && !o_in_stall;
    assign o_in_stall    = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_out_item    = r_out_item;
    assign out_free      = !(r_out_valid && i_out_stall);

    assign load_idx_ext  = XW'(i_in_item.table_index);
    assign load_in_range = (load_idx_ext < XW'(TABLE_WORDS));
    assign load_we       = in_accept && (i_in_item.op == OP_LOAD) && load_in_range;

    // shared mix unit: one xxtea step per element
    assign round_e  = r_sum[3:2];
    assign key_sel  = r_gp[1:0] ^ round_e;
    always_comb begin
        case (key_sel)
            2'd0:    key_word = r_key[0];
            2'd1:    key_word = r_key[1];
            2'd2:    key_word = r_key[2];
            2'd3:    key_word = r_key[3];
            default: key_word = r_key[0];
        endcase
    end
    assign mix_a   = ((r_z >> 5) ^ (ram_rd_data << 2)) + ((ram_rd_data >> 3) ^ (r_z << 4));
    assign mix_b   = (r_sum ^ ram_rd_data) + (key_word ^ r_z);
    assign gen_new = r_cur + r_mix;
    assign gp_inc  = (r_gp == LAST_IDX) ? '0 : r_gp + AW'(1);

    // payload position bookkeeping with first_word applied
    assign pos_eff     = r_first ? '0 : r_pos;
    assign phase_eff   = r_first ? '0 : r_phase;
    assign ptr_eff     = r_first ? '0 : r_ptr;
    assign data_masked = (pos_eff < WORD_W'(HEAD_WORDS)) || (phase_eff == '0);

    always_comb begin
        ram_we      = 1'b0;
        ram_wr_addr = load_idx_ext[AW-1:0];
        ram_wr_data = i_in_item.word_value;
        if (r_state == S_GWR) begin
            ram_we      = 1'b1;
            ram_wr_addr = r_gp;
            ram_wr_data = gen_new;
        end else if (load_we) begin
            ram_we = 1'b1;
        end
    end

    always_comb begin
        ram_re      = 1'b0;
        ram_rd_addr = '0;
        case (r_state)
            S_RSTART: begin
                ram_re      = 1'b1;
                ram_rd_addr = LAST_IDX;
            end
            S_RZ: begin
                ram_re      = 1'b1;
                ram_rd_addr = '0;
            end
            S_GRD: begin
                ram_re      = 1'b1;
                ram_rd_addr = gp_inc;
            end
            S_DRD: begin
                ram_re      = 1'b1;
                ram_rd_addr = ptr_eff;
            end
            default: begin
                ram_re      = 1'b0;
                ram_rd_addr = '0;
            end
        endcase
    end

    xkxd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_WORDS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept && (i_in_item.op == OP_DATA)) begin
                    n_state = (!r_stream_ready && !r_cfg_preset) ? S_RSTART : S_DRD;
                end
            end
            S_RSTART: n_state = S_RZ;
            S_RZ:     n_state = S_RCUR;
            S_RCUR:   n_state = S_GRD;
            S_GRD:    n_state = S_GMIX;
            S_GMIX:   n_state = S_GWR;
            S_GWR: begin
                if (r_gp != LAST_IDX) begin
                    n_state = S_GRD;
                end else if (r_round == RW'(ROUND_COUNT - 1)) begin
                    n_state = S_DRD;
                end else begin
                    n_state = S_RSTART;
                end
            end
            S_DRD:    n_state = S_DOUT;
            S_DOUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_key[0]       <= '0;
            r_key[1]       <= '0;
            r_key[2]       <= '0;
            r_key[3]       <= '0;
            r_cfg_preset   <= 1'b0;
            r_stream_ready <= 1'b0;
            r_pos          <= '0;
            r_phase        <= '0;
            r_ptr          <= '0;
            r_sum          <= '0;
            r_round        <= '0;
            r_gp           <= '0;
            r_z            <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_KEY_ZERO:      r_key[0]     <= i_cfg_data;
                    REG_KEY_ONE:       r_key[1]     <= i_cfg_data;
                    REG_KEY_TWO:       r_key[2]     <= i_cfg_data;
                    REG_KEY_THREE:     r_key[3]     <= i_cfg_data;
                    REG_STREAM_PRESET: r_cfg_preset <= i_cfg_data[0];
                    default:           r_cfg_preset <= r_cfg_preset;
                endcase
            end

            if (r_state == S_DOUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (load_we) begin
                r_stream_ready <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    r_sum   <= '0;
                    r_round <= '0;
                end
                S_RSTART: begin
                    r_sum <= r_sum + KS_DELTA;
                    r_gp  <= '0;
                end
                S_RZ: begin
                    r_z <= ram_rd_data;
                end
                S_GWR: begin
                    r_z  <= gen_new;
                    r_gp <= gp_inc;
                    if (r_gp == LAST_IDX) begin
                        if (r_round == RW'(ROUND_COUNT - 1)) begin
                            r_stream_ready <= 1'b1;
                        end else begin
                            r_round <= r_round + RW'(1);
                        end
                    end
                end
                S_DRD: begin
                    // an unmasked word leaves the pointer where it is
                    r_ptr <= !data_masked ? ptr_eff :
                             (ptr_eff == LAST_IDX) ? '0 : ptr_eff + AW'(1);
                    if (pos_eff != '1) begin
                        r_pos <= pos_eff + WORD_W'(1);
                        if (pos_eff < WORD_W'(HEAD_WORDS)) begin
                            r_phase <= '0;
                        end else if (phase_eff == PW'(STRIDE_WORDS - 1)) begin
                            r_phase <= '0;
                        end else begin
                            r_phase <= phase_eff + PW'(1);
                        end
                    end else begin
                        r_pos   <= pos_eff;
                        r_phase <= phase_eff;
                    end
                end
                default: begin
                    r_sum <= r_sum;
                end
            endcase
        end
    end

    // datapath registers without reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_word  <= i_in_item.word_value;
            r_first <= i_in_item.first_word;
        end
        if (r_state == S_RCUR) begin
            r_cur <= ram_rd_data;
        end
        if (r_state == S_GMIX) begin
            r_y   <= ram_rd_data;
            r_mix <= mix_a ^ mix_b;
        end
        if (r_state == S_GWR) begin
            r_cur <= r_y;
        end
        if (r_state == S_DRD) begin
            r_masked <= data_masked;
        end
        if (r_state == S_DOUT && out_free) begin
            r_out_item.out_word   <= r_masked ? (r_word ^ ram_rd_data) : r_word;
            r_out_item.was_masked <= r_masked;
        end
    end

    a_gen_writes_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GWR) |-> (ram_we && (ram_wr_addr == r_gp)))
        else $error("generation step did not write its table entry");

    a_ready_after_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GWR && r_gp == LAST_IDX && r_round == RW'(ROUND_COUNT - 1))
        |=> (r_stream_ready && r_state == S_DRD))
        else $error("keystream not marked ready after final round");

    a_data_needs_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRD) |-> (r_stream_ready || r_cfg_preset))
        else $error("payload word read before keystream was ready");

    a_out_from_dout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DOUT))
        else $error("result raised outside the output state");

    a_no_read_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (r_state == S_DRD || r_state == S_RSTART
                                || r_state == S_RZ || r_state == S_GRD) && (r_state != S_GWR))
        else $error("table read and generation write in the same cycle");

endmodule

`default_nettype wire

// File: sim/tb.sv
// self-checking testbench for the xxtea keystream xor decrypt unit
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import xkxd_pkg::*;

    localparam int TBL    = TABLE_WORDS_DEF;
    localparam int HEAD   = HEAD_WORDS_DEF;
    localparam int STRIDE = STRIDE_WORDS_DEF;
    localparam int ROUNDS = ROUND_COUNT_DEF;

    localparam int DRAIN_CYCLES  = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 150;
    // enough words to leave the head region and cross one full stride
    localparam int STRIDE_TEST_WORDS = HEAD + STRIDE + 2;
    localparam int TIME_LIMIT_NS = 20_000_000;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_stall;
    t_in_item               i_in_item   = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    t_out_item              o_out_item;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [WORD_W-1:0]      i_cfg_data  = '0;

    xxtea_keystream_xor_decrypt_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIME_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    // keystream predictor state
    bit [WORD_W-1:0] ks_table [TBL];
    bit              ks_ready  = 1'b0;
    bit [31:0]       word_pos  = '0;
    int unsigned     ks_ptr    = 0;
    bit [WORD_W-1:0] key_word [4];
    bit              preset_on = 1'b0;

    t_out_item plaintext_q [$];
    int        mismatch_count = 0;

    // sender and receiver control
    int burst_left    = 0;
    bit offering      = 1'b0;
    int max_gap       = 8;
    int hold_requests = 0;

    function automatic bit [WORD_W-1:0] xxtea_mix(bit [WORD_W-1:0] y, bit [WORD_W-1:0] z,
                                                   bit [WORD_W-1:0] sum, int unsigned p,
                                                   bit [1:0] e);
        bit [WORD_W-1:0] a;
        bit [WORD_W-1:0] b;
        a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
        b = (sum ^ y) + (key_word[p[1:0] ^ e] ^ z);
        return a ^ b;
    endfunction

    // in-place xxtea encryption of the whole table
    function automatic void generate_keystream();
        bit [WORD_W-1:0] sum;
        bit [WORD_W-1:0] prev;
        bit [1:0]        e;
        sum = '0;
        for (int r = 0; r < ROUNDS; r++) begin
            sum  = sum + KS_DELTA;
            e    = sum[3:2];
            prev = ks_table[TBL-1];
            for (int p = 0; p < TBL - 1; p++) begin
                ks_table[p] = ks_table[p] + xxtea_mix(ks_table[p+1], prev, sum, p, e);
                prev        = ks_table[p];
            end
            ks_table[TBL-1] = ks_table[TBL-1] + xxtea_mix(ks_table[0], prev, sum, TBL - 1, e);
        end
    endfunction

    function automatic void predict_plaintext(t_in_item it);
        t_out_item res;
        bit        hit;
        if (it.op == OP_LOAD) begin
            if (int'(it.table_index) < TBL) begin
                ks_table[it.table_index] = it.word_value;
                ks_ready = 1'b0;
            end
            return;
        end
        if (!ks_ready && !preset_on) begin
            generate_keystream();
            ks_ready = 1'b1;
        end
        if (it.first_word) begin
            word_pos = '0;
            ks_ptr   = 0;
        end
        hit = (word_pos < 32'(HEAD)) || ((word_pos - 32'(HEAD)) % 32'(STRIDE) == 0);
        res.out_word = it.word_value;
        if (hit) begin
            res.out_word = res.out_word ^ ks_table[ks_ptr];
            ks_ptr = (ks_ptr + 1 >= TBL) ? 0 : ks_ptr + 1;
        end
        res.was_masked = hit;
        if (word_pos != '1) begin
            word_pos++;
        end
        plaintext_q.push_back(res);
    endfunction

    function automatic t_in_item data_item(logic [WORD_W-1:0] value, logic first);
        t_in_item it;
        it.op          = OP_DATA;
        it.table_index = TABLE_INDEX_W'($urandom());
        it.word_value  = value;
        it.first_word  = first;
        return it;
    endfunction

    function automatic t_in_item load_item(int idx, logic [WORD_W-1:0] value);
        t_in_item it;
        it.op          = OP_LOAD;
        it.table_index = TABLE_INDEX_W'(idx);
        it.word_value  = value;
        it.first_word  = 1'($urandom());
        return it;
    endfunction

    function automatic logic [WORD_W-1:0] pick_key();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_item(t_in_item it);
        if (!offering) begin
            if (burst_left == 0) begin
                repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 40 : max_gap))
                    @(posedge i_clk);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                          : $urandom_range(1, 12);
            end
            offering = 1'b1;
            i_in_valid <= 1'b1;
        end
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_plaintext(it);
        burst_left--;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic stop_sending();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_results();
        stop_sending();
        while (plaintext_q.size() != 0) @(posedge i_clk);
    endtask

    // loads leave no result behind, so also let the block drain after the queue empties
    task automatic settle();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [WORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_KEY_ZERO:      key_word[0] = data;
            REG_KEY_ONE:       key_word[1] = data;
            REG_KEY_TWO:       key_word[2] = data;
            REG_KEY_THREE:     key_word[3] = data;
            REG_STREAM_PRESET: preset_on   = data[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic random_config();
        logic [WORD_W-1:0] preset_word;
        settle();
        write_reg(REG_KEY_ZERO, pick_key());
        write_reg(REG_KEY_ONE, pick_key());
        write_reg(REG_KEY_TWO, pick_key());
        write_reg(REG_KEY_THREE, pick_key());
        preset_word    = $urandom();
        preset_word[0] = ($urandom_range(0, 3) == 0);
        write_reg(REG_STREAM_PRESET, preset_word);
        if ($urandom_range(0, 3) == 0) begin
            write_reg(CFG_INDEX_W'($urandom_range(REG_STREAM_PRESET + 1,
                                                  (1 << CFG_INDEX_W) - 1)), $urandom());
        end
    endtask

    // receiver: random stall patterns plus long holds on request
    int          holds_done = 0;
    int          hold_left  = 0;
    int          mode_left  = 0;
    t_stall_mode stall_mode = STALL_NONE;

    always @(posedge i_clk) begin
        if (hold_left == 0 && hold_requests != holds_done) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
        end
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                default:     i_out_stall <= mode_left[2];
            endcase
        end
    end

    always @(posedge i_clk) begin : check_out
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (plaintext_q.size() == 0) begin
                $error("unexpected transaction: out_word %h was_masked %b",
                       o_out_item.out_word, o_out_item.was_masked);
                mismatch_count++;
            end else begin
                want = plaintext_q.pop_front();
                if (o_out_item.out_word !== want.out_word) begin
                    $error("out_word mismatch: expected %h, got %h",
                           want.out_word, o_out_item.out_word);
                    mismatch_count++;
                end
                if (o_out_item.was_masked !== want.was_masked) begin
                    $error("was_masked mismatch: expected %b, got %b",
                           want.was_masked, o_out_item.was_masked);
                    mismatch_count++;
                end
            end
        end
    end

    // every entry must be written before generation reads the table
    task automatic test_fill_table();
        write_reg(REG_KEY_ZERO, '0);
        write_reg(REG_KEY_ONE, '1);
        write_reg(REG_KEY_TWO, KS_DELTA);
        write_reg(REG_KEY_THREE, $urandom());
        write_reg(REG_STREAM_PRESET, '0);
        for (int i = 0; i < TBL; i++) begin
            send_item(load_item(i, (i == 0) ? '0 : (i == TBL - 1) ? '1 : $urandom()));
        end
    endtask

    task automatic test_no_first_word();
        send_item(data_item('0, 1'b0));
        send_item(data_item('1, 1'b0));
        send_item(data_item($urandom(), 1'b0));
    endtask

    task automatic test_first_word_restart();
        send_item(data_item($urandom(), 1'b1));
        send_item(data_item($urandom(), 1'b0));
        send_item(data_item($urandom(), 1'b0));
        send_item(data_item($urandom(), 1'b1));
    endtask

    task automatic test_reload_after_gen();
        send_item(load_item(TBL - 1, $urandom()));
        send_item(load_item(0, $urandom()));
        send_item(data_item($urandom(), 1'b1));
        send_item(data_item($urandom(), 1'b0));
    endtask

    task automatic test_preset();
        settle();
        write_reg(REG_STREAM_PRESET, 32'h1);
        for (int i = 0; i < 4; i++) begin
            send_item(load_item(i, (i == 0) ? '1 : $urandom()));
        end
        send_item(data_item('0, 1'b1));
        send_item(data_item('1, 1'b0));
        send_item(data_item($urandom(), 1'b0));
        settle();
        write_reg(REG_KEY_ZERO, '1);
        write_reg(REG_KEY_ONE, '1);
        write_reg(REG_KEY_TWO, '1);
        write_reg(REG_KEY_THREE, '1);
        write_reg(REG_STREAM_PRESET, '0);
        // loads under preset left the stream stale, so this regenerates
        send_item(data_item($urandom(), 1'b1));
        send_item(data_item($urandom(), 1'b0));
    endtask

    task automatic test_backpressure();
        hold_requests++;
        send_item(data_item($urandom(), 1'b1));
        repeat (39) send_item(data_item($urandom(), 1'b0));
        wait_results();
        repeat (20) send_item(data_item($urandom(), 1'b0));
    endtask

    task automatic test_random_streams();
        int sent;
        int seg_len;
        int n_loads;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            max_gap = $urandom_range(1, 12);
            if ($urandom_range(0, 2) == 0) begin
                random_config();
            end
            if ($urandom_range(0, 9) < 6) begin
                n_loads = $urandom_range(1, 4);
                repeat (n_loads) send_item(load_item($urandom_range(0, TBL - 1), $urandom()));
                sent += n_loads;
            end
            seg_len = $urandom_range(5, 60);
            for (int i = 0; i < seg_len; i++) begin
                // stray load in the middle of a stream
                if ($urandom_range(0, 99) == 0) begin
                    send_item(load_item($urandom_range(0, TBL - 1), $urandom()));
                    sent++;
                end
                send_item(data_item($urandom(), (i == 0) ? ($urandom_range(0, 9) != 0)
                                                         : ($urandom_range(0, 99) == 0)));
            end
            sent += seg_len;
        end
    endtask

    task automatic test_stride_region();
        max_gap = 2;
        send_item(data_item($urandom(), 1'b1));
        repeat (STRIDE_TEST_WORDS - 1) send_item(data_item($urandom(), 1'b0));
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_table();
        test_no_first_word();
        test_first_word_restart();
        test_reload_after_gen();
        test_preset();
        test_backpressure();
        test_random_streams();
        test_stride_region();
        settle();
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: xxtea_keystream_xor_decrypt_unit.f
hw/rtl/xkxd_pkg.sv
hw/rtl/xkxd_ram.sv
hw/rtl/xxtea_keystream_xor_decrypt_unit.sv
sim/tb.sv
